>>> sv/recent_string_list_defines.svh
// Assertion macros shared by the checker.
`ifndef RECENT_STRING_LIST_DEFINES_SVH
`define RECENT_STRING_LIST_DEFINES_SVH
`define RSL_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: label failed");
`define RSL_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: label failed");
`endif

>>> sv/rsl_pkg.sv
`timescale 1ns / 1ps
package rsl_pkg;
  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_WORD     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] read_index;
  } cmd_t;
endpackage

>>> sv/recent_string_list.sv
`timescale 1ns / 1ps
// recent_string_list: move-to-front list of up to CAPACITY strings.
// Input: pulse start with busy low. func 0 stages a word of a string
// (word_data, word_bytes); word_last closes it. func 1 reads entry read_index.
// Results: one cycle each, marked by strobe; the receiver cannot stall, so
// nothing here ever waits on the output side.
// A closing word gives one result (added or rejected). A read gives one
// result per stored word, or one not-found result.
// Staging words are accepted one per cycle while busy is low. A closing word
// runs a match search (word by word over each entry of the staged length; an
// entry of another length fails without a word compare), then a shift of the
// moved entries word by word through the entry memory, then a copy of the
// staged string. A read gives the words of its entry in order. busy is high
// while a command waits for or is in the sequencer.
// Reset empties the list and the staging buffer; memory contents are not
// cleared and there is no clearing pass.
module recent_string_list #(
  parameter int CAPACITY = 16,
  parameter int MAX_LEN  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] word_data,
  input  logic [3:0]  word_bytes,
  input  logic        word_last,
  input  logic [7:0]  read_index,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [63:0] out_data,
  output logic [3:0]  out_bytes,
  output logic        out_last,
  output logic [4:0]  entry_total
);
  localparam int WORDS = (MAX_LEN + 7) / 8;
  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic q_valid, q_pop, stg_clear;
  rsl_pkg::cmd_t q_cmd;
  logic [WW-1:0] stg_raddr;
  logic [63:0] stg_rdata;
  logic [LW-1:0] stg_len;

  rsl_front #(.MAX_LEN(MAX_LEN), .WORDS(WORDS), .WW(WW), .LW(LW)) u_front (
    .clk, .rst, .start, .func, .word_data, .word_bytes, .word_last,
    .read_index, .busy, .q_valid, .q_cmd, .q_pop, .stg_raddr, .stg_rdata,
    .stg_len, .stg_clear
  );

  rsl_back #(.CAPACITY(CAPACITY), .MAX_LEN(MAX_LEN), .WORDS(WORDS), .WW(WW),
             .LW(LW), .EW(EW), .CW(CW)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .stg_raddr, .stg_rdata, .stg_len,
    .stg_clear, .strobe, .status, .out_data, .out_bytes, .out_last, .entry_total
  );
endmodule

>>> sv/rsl_front.sv
`timescale 1ns / 1ps
// Stages string bytes; emits close or read commands into a one-entry queue.
module rsl_front #(
  parameter int MAX_LEN = 256,
  parameter int WORDS   = 32,
  parameter int WW      = 5,
  parameter int LW      = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [63:0]       word_data,
  input  logic [3:0]        word_bytes,
  input  logic              word_last,
  input  logic [7:0]        read_index,
  output logic              busy,
  output logic              q_valid,
  output rsl_pkg::cmd_t     q_cmd,
  input  logic              q_pop,
  input  logic [WW-1:0]     stg_raddr,
  output logic [63:0]       stg_rdata,
  output logic [LW-1:0]     stg_len,
  input  logic              stg_clear
);
  logic [63:0]   staging_words [WORDS];
  logic [LW-1:0] staging_length;
  logic          string_ended;
  logic [3:0]    nb;
  logic [LW-1:0] len_next;
  logic          ended_next;
  logic [63:0]   wbuf;
  logic [7:0]    wmask;
  logic          accept;
  logic [7:0]    b;

  assign busy   = q_valid;
  assign accept = start && !busy;
  assign nb     = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
  assign stg_len = staging_length;

  always_comb begin
    len_next   = staging_length;
    ended_next = string_ended;
    wbuf       = '0;
    wmask      = '0;
    b          = '0;
    for (int i = 0; i < 8; i++) begin
      b = word_data[i*8 +: 8];
      if (i < 32'(nb) && !ended_next) begin
        if (b == 8'd0) begin
          ended_next = 1'b1;
        end else if (32'(len_next) < MAX_LEN) begin
          wbuf[i*8 +: 8] = b;
          wmask[i] = 1'b1;
          len_next = len_next + 1'b1;
        end
      end
    end
  end

  // Bytes land at staging_length onward; write up to two words.
  logic [2:0]    sh;
  logic [WW-1:0] wi0, wi1;
  logic [127:0]  shd;
  logic [15:0]   shm;
  assign sh  = staging_length[2:0];
  assign wi0 = WW'(staging_length >> 3);
  assign wi1 = wi0 + 1'b1;
  always_comb begin
    shd = {64'd0, wbuf};
    shm = {8'd0, wmask};
    for (int i = 0; i < 8; i++) begin
      shd[64 + i*8 +: 8] = 8'd0;
    end
    shd = shd << (32'(sh) * 8);
    shm = shm << sh;
  end

  always_ff @(posedge clk) begin
    if (accept && func == rsl_pkg::FUNC_ADD) begin
      for (int i = 0; i < 8; i++) begin
        if (shm[i]) staging_words[wi0][i*8 +: 8] <= shd[i*8 +: 8];
        if (shm[8+i] && 32'(wi1) < WORDS) staging_words[wi1][i*8 +: 8] <= shd[64+i*8 +: 8];
      end
    end
    stg_rdata <= staging_words[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staging_length <= '0;
      string_ended   <= 1'b0;
      q_valid        <= 1'b0;
    end else begin
      if (stg_clear) begin
        staging_length <= '0;
        string_ended   <= 1'b0;
      end
      if (q_pop) q_valid <= 1'b0;
      if (accept) begin
        if (func == rsl_pkg::FUNC_ADD) begin
          staging_length <= len_next;
          string_ended   <= ended_next;
          if (word_last) begin
            q_valid <= 1'b1;
            q_cmd   <= '{func: rsl_pkg::FUNC_ADD, read_index: 8'd0};
          end
        end else begin
          q_valid <= 1'b1;
          q_cmd   <= '{func: rsl_pkg::FUNC_READ, read_index: read_index};
        end
      end
    end
  end
endmodule

>>> sv/rsl_back.sv
`timescale 1ns / 1ps
// Sequencer: match search, shift, copy-in and read-out over one memory.
module rsl_back #(
  parameter int CAPACITY = 16,
  parameter int MAX_LEN  = 256,
  parameter int WORDS    = 32,
  parameter int WW       = 5,
  parameter int LW       = 9,
  parameter int EW       = 4,
  parameter int CW       = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rsl_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic [WW-1:0]  stg_raddr,
  input  logic [63:0]    stg_rdata,
  input  logic [LW-1:0]  stg_len,
  output logic           stg_clear,
  output logic           strobe,
  output logic [1:0]     status,
  output logic [63:0]    out_data,
  output logic [3:0]     out_bytes,
  output logic           out_last,
  output logic [4:0]     entry_total
);
  localparam int AW = EW + WW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CMP   = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_COPY  = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_DONE  = 8'b0010_0000,
    S_WAIT  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [63:0]   mem [CAPACITY*WORDS];
  logic [LW-1:0] entry_length [CAPACITY];
  logic [CW-1:0] total;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   wdata, rdata;
  logic [EW-1:0] e, n;
  logic [WW-1:0] k, nwords;
  logic          mismatch, rd_pend, st_pend;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  function automatic logic [AW-1:0] adr(logic [EW-1:0] ei, logic [WW-1:0] wi);
    return AW'(ei) * AW'(WORDS) + AW'(wi);
  endfunction

  function automatic logic [7:0] compare_fail(logic [63:0] a, logic [63:0] s,
                                              logic [WW-1:0] kk, logic [LW-1:0] l);
    logic [7:0] f;
    f = '0;
    for (int i = 0; i < 8; i++)
      f[i] = (32'({kk, 3'd0}) + i < 32'(l)) && (a[i*8 +: 8] != s[i*8 +: 8]);
    return f;
  endfunction

  logic [LW-1:0] rem;
  logic [LW-1:0] cur_len;
  assign cur_len = entry_length[e];
  assign rem = cur_len - LW'({k, 3'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      total   <= '0;
      strobe  <= 1'b0;
      q_pop   <= 1'b0;
      stg_clear <= 1'b0;
      we      <= 1'b0;
      rd_pend <= 1'b0;
      st_pend <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      q_pop     <= 1'b0;
      stg_clear <= 1'b0;
      we        <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !q_pop) begin
            k <= '0; e <= '0; mismatch <= 1'b0; rd_pend <= 1'b0;
            if (q_cmd.func == rsl_pkg::FUNC_READ) begin
              if (32'(q_cmd.read_index) >= 32'(total)) begin
                status <= rsl_pkg::ST_NONE; state <= S_EMIT;
              end else begin
                e <= EW'(q_cmd.read_index);
                nwords <= WW'((32'(entry_length[EW'(q_cmd.read_index)]) + 7) / 8);
                raddr <= adr(EW'(q_cmd.read_index), '0);
                state <= S_READ;
              end
            end else if (stg_len == '0 || 32'(stg_len) >= MAX_LEN) begin
              status <= rsl_pkg::ST_REJECTED; state <= S_EMIT;
            end else if (total == '0) begin
              n <= '0; state <= S_DONE;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          // mem and staging read in lockstep; the next word only after this one is compared
          if (!rd_pend) begin
            if (entry_length[e] != stg_len) begin
              mismatch <= 1'b1; rd_pend <= 1'b1;
            end else begin
              raddr <= adr(e, k); stg_raddr <= k; rd_pend <= 1'b1;
            end
          end else if (!st_pend) begin
            st_pend <= 1'b1;
          end else begin
            st_pend <= 1'b0; rd_pend <= 1'b0;
            if (mismatch || |compare_fail(rdata, stg_rdata, k, stg_len)) begin
              k <= '0; mismatch <= 1'b0;
              if (32'(e) + 1 >= 32'(total)) begin
                if (32'(total) < CAPACITY) begin
                  n <= EW'(total); total <= total + 1'b1;
                end else n <= EW'(CAPACITY - 1);
                state <= S_SHIFT;
              end else e <= e + 1'b1;
            end else if (32'({k, 3'd0}) + 8 >= 32'(stg_len)) begin
              k <= '0; n <= e; state <= S_SHIFT;
            end else k <= k + 1'b1;
          end
        end
        S_SHIFT: begin
          // move entry n-1 to n, word by word: read, wait for the read data, then write
          if (n == '0) begin
            k <= '0; rd_pend <= 1'b0; state <= S_COPY;
          end else if (!rd_pend) begin
            raddr <= adr(n - 1'b1, k); rd_pend <= 1'b1;
          end else if (!st_pend) begin
            st_pend <= 1'b1;
          end else begin
            st_pend <= 1'b0; rd_pend <= 1'b0;
            we <= 1'b1; waddr <= adr(n, k); wdata <= rdata;
            if (32'(k) == WORDS - 1) begin
              entry_length[n] <= entry_length[n - 1'b1];
              k <= '0; n <= n - 1'b1;
            end else k <= k + 1'b1;
          end
        end
        S_COPY: begin
          if (!rd_pend) begin
            stg_raddr <= k; rd_pend <= 1'b1;
          end else if (!st_pend) begin
            st_pend <= 1'b1;
          end else begin
            st_pend <= 1'b0; rd_pend <= 1'b0;
            we <= 1'b1; waddr <= adr('0, k); wdata <= stg_rdata;
            if (32'(k) == WORDS - 1) begin
              entry_length[0] <= stg_len;
              status <= rsl_pkg::ST_ADDED; state <= S_EMIT;
            end else k <= k + 1'b1;
          end
        end
        S_DONE: begin
          n <= '0; total <= total + 1'b1; k <= '0; state <= S_COPY;
        end
        S_READ: begin
          if (!rd_pend) begin
            raddr <= adr(e, k); rd_pend <= 1'b1;
          end else if (!st_pend) begin
            st_pend <= 1'b1;
          end else begin
            st_pend <= 1'b0; rd_pend <= 1'b0;
            strobe <= 1'b1; status <= rsl_pkg::ST_WORD;
            for (int i = 0; i < 8; i++)
              out_data[i*8 +: 8] <= (32'(i) < 32'(rem)) ? rdata[i*8 +: 8] : 8'd0;
            out_bytes <= (32'(rem) > 8) ? 4'd8 : 4'(rem);
            out_last <= (k + 1'b1 == nwords);
            entry_total <= 5'(total);
            if (k + 1'b1 == nwords) begin
              q_pop <= 1'b1; state <= S_WAIT;
            end else k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1; out_data <= '0; out_bytes <= '0; out_last <= 1'b1;
          entry_total <= 5'(total); q_pop <= 1'b1;
          if (status != rsl_pkg::ST_NONE) stg_clear <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/rsl_checker.sv
`timescale 1ns / 1ps
`include "recent_string_list_defines.svh"
module rsl_checker #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [1:0] status,
  input logic [3:0] out_bytes,
  input logic       out_last,
  input logic [4:0] entry_total
);
  `RSL_ASSERT_IMPL(a_nonword_last, clk, rst,
    strobe && status != rsl_pkg::ST_WORD, out_last && out_bytes == 4'd0)
  `RSL_ASSERT_IMPL(a_word_bytes, clk, rst,
    strobe && status == rsl_pkg::ST_WORD, out_bytes != 4'd0 && out_bytes <= 4'd8)
  `RSL_ASSERT_IMPL(a_total_range, clk, rst, strobe, 32'(entry_total) <= CAPACITY)
  `RSL_ASSERT_IMPL(a_strobe_busy, clk, rst, strobe, busy)
  `RSL_ASSERT_NEXT(a_last_ends, clk, rst, strobe && out_last, !strobe)
endmodule

bind recent_string_list rsl_checker #(.CAPACITY(CAPACITY)) u_chk (
  .clk, .rst, .busy, .strobe, .status, .out_bytes, .out_last, .entry_total
);
